// ===== sv/fdp_pkg.sv =====
package fdp_pkg;

    localparam int DISPLAYS = 4;
    localparam int DISP_W   = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;

    localparam int TIME_W = 64;
    localparam int IV_W   = 20;
    localparam int RATE_W = 12;
    localparam int TOL_W  = 16;
    localparam int DSP_W  = 8;

    // serial datapath: one 4-bit digit per cycle, least significant first
    localparam int DIG_W = 4;
    localparam int NDIG  = TIME_W / DIG_W;
    localparam int CNT_W = 5;

    localparam logic [IV_W-1:0]   DEFAULT_IV   = IV_W'(16666);
    localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(60);
    localparam logic [IV_W-1:0]   US_PER_SEC   = IV_W'(1000000);
    localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(1000);

    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_SET_RATE  = 3'd1;
    localparam logic [2:0] OP_NEXT      = 3'd2;
    localparam logic [2:0] OP_EVAL      = 3'd3;
    localparam logic [2:0] OP_PRESENTED = 3'd4;

    localparam logic [1:0] V_READY = 2'd0;
    localparam logic [1:0] V_BURST = 2'd1;
    localparam logic [1:0] V_LATE  = 2'd2;
    localparam logic [1:0] V_WAIT  = 2'd3;

endpackage

// ===== sv/frame_deadline_pacer_unit.sv =====
// Frame deadline pacer for up to DISPLAYS displays. A request is taken when
// start is high and busy is low; exactly one result follows, shown for one
// cycle with done high, and the receiver cannot stall it. Next-deadline,
// evaluate and presented requests run the 64-bit times through a 4-bit
// digit-serial datapath. Init and set-rate run a restoring divider one
// quotient bit per cycle. Requests on an invalid display for init, set-rate
// or presented, and unused request codes, go straight to the final state.
// A new request can be taken in the cycle done is high. The jitter
// tolerance register is written through cfg_we/cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
module frame_deadline_pacer_unit
    import fdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        req_type,
    input  logic [DSP_W-1:0]  display,
    input  logic [RATE_W-1:0] rate_hz,
    input  logic [TIME_W-1:0] now_us,
    input  logic [TIME_W-1:0] request_deadline,
    input  logic              cfg_we,
    input  logic [TOL_W-1:0]  cfg_data,
    output logic              done,
    output logic              status,
    output logic [1:0]        verdict,
    output logic [TIME_W-1:0] deadline_us
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SER  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [TOL_W-1:0] tol_reg;

    logic              act_reg [DISPLAYS];
    logic [TIME_W-1:0] lp_reg  [DISPLAYS];
    logic [TIME_W-1:0] nd_reg  [DISPLAYS];
    logic [IV_W-1:0]   iv_reg  [DISPLAYS];

    logic [2:0]        op_reg;
    logic [DISP_W-1:0] idx_reg;
    logic              valid_reg;
    logic              live_reg;   // valid and active

    logic [TIME_W-1:0] sh_now_reg, sh_req_reg, sh_lp_reg, sh_nd_reg, sh_sum_reg;
    logic [IV_W-1:0]   sh_add_reg, sh_half_reg;
    logic [TOL_W-1:0]  sh_tol_reg;

    logic c1_reg, c2_reg, c3_reg, c4_reg, b_reg;
    logic lp_nz_reg, nd_nz_reg, nd_gt_now_reg, now_gt_lp_reg;
    logic diff_lt_half_reg, s3_lt_req_reg, now_gt_s4_reg;

    logic [RATE_W:0]   rem_reg;
    logic [IV_W-1:0]   quo_reg;
    logic [RATE_W-1:0] div_reg;

    logic              done_reg, status_reg;
    logic [1:0]        verdict_reg;
    logic [TIME_W-1:0] deadline_reg;

    logic [DISP_W-1:0] in_idx;
    logic              in_valid, in_live, accept;
    logic [IV_W-1:0]   in_iv;

    logic [DIG_W-1:0] n_d, r_d, l_d, x_d, a_d, h_d, t_d;
    logic [DIG_W:0]   s1, s2, s3, s4, df;

    logic [RATE_W:0]   rem_sh;
    logic              rem_ge;

    logic [TIME_W-1:0] nd_new;
    logic [1:0]        eval_v;

    assign accept   = start && !busy;
    assign in_idx   = display[DISP_W-1:0];
    assign in_valid = (32'(display) < DISPLAYS);
    assign in_live  = in_valid && act_reg[in_idx];
    assign in_iv    = iv_reg[in_idx];

    // current digits
    assign n_d = sh_now_reg[DIG_W-1:0];
    assign r_d = sh_req_reg[DIG_W-1:0];
    assign l_d = sh_lp_reg[DIG_W-1:0];
    assign x_d = sh_nd_reg[DIG_W-1:0];
    assign a_d = sh_add_reg[DIG_W-1:0];
    assign h_d = sh_half_reg[DIG_W-1:0];
    assign t_d = sh_tol_reg[DIG_W-1:0];

    assign s1 = {1'b0, n_d} + {1'b0, a_d} + {{DIG_W{1'b0}}, c1_reg};  // now + interval
    assign s2 = {1'b0, x_d} + {1'b0, a_d} + {{DIG_W{1'b0}}, c2_reg};  // deadline + interval
    assign s3 = {1'b0, n_d} + {1'b0, t_d} + {{DIG_W{1'b0}}, c3_reg};  // now + tolerance
    assign s4 = {1'b0, r_d} + {1'b0, a_d} + {{DIG_W{1'b0}}, c4_reg};  // request + interval
    assign df = {1'b0, n_d} - {1'b0, l_d} - {{DIG_W{1'b0}}, b_reg};   // now - last present

    assign rem_sh = {rem_reg[RATE_W-1:0], quo_reg[IV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    case (req_type)
                        OP_NEXT, OP_EVAL: state_next = ST_SER;
                        OP_PRESENTED:     state_next = in_valid ? ST_SER : ST_FIN;
                        OP_INIT, OP_SET_RATE: state_next = in_valid ? ST_DIV : ST_FIN;
                        default:          state_next = ST_FIN;
                    endcase
                end
            end
            ST_SER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDIG - 1))
                    state_next = ST_FIN;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(IV_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // final decisions from the serial flags
    always_comb
    begin
        if (!lp_nz_reg)
            nd_new = sh_now_reg;
        else if (!nd_nz_reg || !nd_gt_now_reg)
            nd_new = sh_sum_reg;
        else
            nd_new = sh_nd_reg;

        if (!live_reg)
            eval_v = V_READY;
        else if (lp_nz_reg && now_gt_lp_reg && diff_lt_half_reg)
            eval_v = V_BURST;
        else if (!s3_lt_req_reg)
            eval_v = now_gt_s4_reg ? V_LATE : V_READY;
        else
            eval_v = V_WAIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            tol_reg   <= TOL_RESET;
            done_reg  <= 1'b0;
            for (int i = 0; i < DISPLAYS; i++)
            begin
                act_reg[i] <= 1'b0;
                lp_reg[i]  <= '0;
                nd_reg[i]  <= '0;
                iv_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == ST_FIN);
            if (cfg_we)
                tol_reg <= cfg_data;

            if (state_reg == ST_FIN && valid_reg)
            begin
                case (op_reg)
                    OP_INIT:
                    begin
                        act_reg[idx_reg] <= 1'b1;
                        lp_reg[idx_reg]  <= '0;
                        nd_reg[idx_reg]  <= '0;
                        iv_reg[idx_reg]  <= quo_reg;
                    end
                    OP_SET_RATE: iv_reg[idx_reg] <= quo_reg;
                    OP_NEXT:
                    begin
                        if (live_reg)
                            nd_reg[idx_reg] <= nd_new;
                    end
                    OP_PRESENTED:
                    begin
                        lp_reg[idx_reg] <= sh_now_reg;
                        if (!nd_gt_now_reg)
                            nd_reg[idx_reg] <= sh_sum_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req_type;
            idx_reg     <= in_idx;
            valid_reg   <= in_valid;
            live_reg    <= in_live;
            sh_now_reg  <= now_us;
            sh_req_reg  <= request_deadline;
            sh_lp_reg   <= lp_reg[in_idx];
            sh_nd_reg   <= nd_reg[in_idx];
            sh_sum_reg  <= '0;
            sh_add_reg  <= (req_type == OP_NEXT && !in_live) ? DEFAULT_IV : in_iv;
            sh_half_reg <= in_iv >> 1;
            sh_tol_reg  <= tol_reg;
            c1_reg <= 1'b0;
            c2_reg <= 1'b0;
            c3_reg <= 1'b0;
            c4_reg <= 1'b0;
            b_reg  <= 1'b0;
            lp_nz_reg        <= 1'b0;
            nd_nz_reg        <= 1'b0;
            nd_gt_now_reg    <= 1'b0;
            now_gt_lp_reg    <= 1'b0;
            diff_lt_half_reg <= 1'b0;
            s3_lt_req_reg    <= 1'b0;
            now_gt_s4_reg    <= 1'b0;
            rem_reg <= '0;
            quo_reg <= US_PER_SEC;
            div_reg <= (rate_hz != '0) ? rate_hz : DEFAULT_RATE;
        end
        else if (state_reg == ST_SER)
        begin
            sh_now_reg  <= {n_d, sh_now_reg[TIME_W-1:DIG_W]};
            sh_req_reg  <= {{DIG_W{1'b0}}, sh_req_reg[TIME_W-1:DIG_W]};
            sh_lp_reg   <= {{DIG_W{1'b0}}, sh_lp_reg[TIME_W-1:DIG_W]};
            sh_nd_reg   <= {s2[DIG_W-1:0], sh_nd_reg[TIME_W-1:DIG_W]};
            sh_sum_reg  <= {s1[DIG_W-1:0], sh_sum_reg[TIME_W-1:DIG_W]};
            sh_add_reg  <= {{DIG_W{1'b0}}, sh_add_reg[IV_W-1:DIG_W]};
            sh_half_reg <= {{DIG_W{1'b0}}, sh_half_reg[IV_W-1:DIG_W]};
            sh_tol_reg  <= {{DIG_W{1'b0}}, sh_tol_reg[TOL_W-1:DIG_W]};
            c1_reg <= s1[DIG_W];
            c2_reg <= s2[DIG_W];
            c3_reg <= s3[DIG_W];
            c4_reg <= s4[DIG_W];
            b_reg  <= df[DIG_W];
            lp_nz_reg <= lp_nz_reg | (|l_d);
            nd_nz_reg <= nd_nz_reg | (|x_d);
            // LSB-first compares: the highest differing digit decides
            if (x_d != n_d)
                nd_gt_now_reg <= (x_d > n_d);
            if (n_d != l_d)
                now_gt_lp_reg <= (n_d > l_d);
            if (df[DIG_W-1:0] != h_d)
                diff_lt_half_reg <= (df[DIG_W-1:0] < h_d);
            if (s3[DIG_W-1:0] != r_d)
                s3_lt_req_reg <= (s3[DIG_W-1:0] < r_d);
            if (n_d != s4[DIG_W-1:0])
                now_gt_s4_reg <= (n_d > s4[DIG_W-1:0]);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_reg <= {quo_reg[IV_W-2:0], rem_ge};
        end

        if (state_reg == ST_FIN)
        begin
            status_reg   <= !valid_reg && (op_reg <= OP_PRESENTED);
            verdict_reg  <= (op_reg == OP_EVAL) ? eval_v : V_READY;
            if (op_reg == OP_NEXT)
                deadline_reg <= live_reg ? nd_new : sh_sum_reg;
            else
                deadline_reg <= '0;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign verdict     = verdict_reg;
    assign deadline_us = deadline_reg;

endmodule
